// ===== rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL files.
// Both macros sample on the rising edge of clk and are held off while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property check
`define ASSERT_CLK(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication check
`define ASSERT_IMPLIES(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== rtl/stptx_pkg.sv =====
`timescale 1ns / 1ps

package stptx_pkg;

    // Field widths
    localparam int ROLE_W  = 2;
    localparam int TIMER_W = 4;
    localparam int COUNT_W = 4;
    localparam int INFO_W  = 2;
    localparam int KIND_W  = 2;
    localparam int CFG_W   = 16;
    localparam int CFG_IDX_W = 2;

    // Instance fields carry at most this many trees
    localparam int FIELD_INST = 16;
    localparam int MSTI_COUNT_DEF = 16;

    // Port role codes
    localparam logic [ROLE_W-1:0] ROLE_OTHER  = 2'd0;
    localparam logic [ROLE_W-1:0] ROLE_ROOT   = 2'd1;
    localparam logic [ROLE_W-1:0] ROLE_DESIG  = 2'd2;
    localparam logic [ROLE_W-1:0] ROLE_MASTER = 2'd3;

    // BPDU kinds
    localparam logic [KIND_W-1:0] SEND_NONE   = 2'd0;
    localparam logic [KIND_W-1:0] SEND_CONFIG = 2'd1;
    localparam logic [KIND_W-1:0] SEND_TCN    = 2'd2;
    localparam logic [KIND_W-1:0] SEND_RSTP   = 2'd3;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TX_HOLD_LIMIT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HELLO_TIME    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TX_LOCK       = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MSTI_MASK     = 2'd3;

    // Register reset values
    localparam logic [COUNT_W-1:0]    RST_TX_HOLD_LIMIT = 4'd6;
    localparam logic [TIMER_W-1:0]    RST_HELLO_TIME    = 4'd2;
    localparam logic                  RST_TX_LOCK       = 1'b0;
    localparam logic [FIELD_INST-1:0] RST_MSTI_MASK     = 16'h0000;

    // Flags one instance lane reports
    typedef struct packed {
        logic upd;      // designated, or root with tc running
        logic master;   // master role
    } stptx_lane_flag_t;

    // Bridge-wide settings used by the decision stage
    typedef struct packed {
        logic [COUNT_W-1:0] hold_limit;
        logic [TIMER_W-1:0] hello_time;
        logic               lock;
    } stptx_cfg_t;

    // Per-port variables of one input beat (instance fields go to the lanes)
    typedef struct packed {
        logic               begin_flag;
        logic               port_up;
        logic               bpdu_filtered;
        logic               transmit_ready;
        logic [TIMER_W-1:0] hello_left;
        logic [COUNT_W-1:0] sent_count;
        logic               rstp_mode;
        logic [INFO_W-1:0]  pending_info;
        logic [ROLE_W-1:0]  cist_role;
        logic               cist_tc_active;
    } stptx_item_t;

    // One result beat
    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [INFO_W-1:0]  info;
        logic [COUNT_W-1:0] count;
        logic [TIMER_W-1:0] hello;
        logic               clr;
        logic               skip;
    } stptx_result_t;

endpackage

// ===== rtl/stp_port_transmit_decision_core.sv =====
// Spanning-tree port transmit decision.
// Path: lanes and merge, then the output register that holds the result beat.
// Throughput: 1 beat per cycle unless out_ready stalls; set by the single output register, which loads
// whenever it is empty or its beat is taken in the same cycle.
// Reset: valid and the configuration registers clear to defaults; results are not reset.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module stp_port_transmit_decision_core
    import stptx_pkg::*;
#(
    parameter int MSTI_COUNT = MSTI_COUNT_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    // configuration
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    // input channel
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 begin_flag,
    input  logic                 port_up,
    input  logic                 bpdu_filtered,
    input  logic                 transmit_ready,
    input  logic [TIMER_W-1:0]   hello_left,
    input  logic [COUNT_W-1:0]   sent_count,
    input  logic                 rstp_mode,
    input  logic [INFO_W-1:0]    pending_info,
    input  logic [ROLE_W-1:0]    cist_role,
    input  logic                 cist_tc_active,
    input  logic [31:0]          msti_roles,
    input  logic [FIELD_INST-1:0] msti_tc_active,
    // output channel
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [KIND_W-1:0]    send_kind,
    output logic [INFO_W-1:0]    pending_info_next,
    output logic [COUNT_W-1:0]   sent_count_next,
    output logic [TIMER_W-1:0]   hello_left_next,
    output logic                 clear_tc_ack,
    output logic                 skipped
);

    // Only the instances the fields carry are examined
    localparam int LANE_COUNT = (MSTI_COUNT > FIELD_INST) ? FIELD_INST : MSTI_COUNT;

    logic [COUNT_W-1:0]    hold_limit_reg;
    logic [TIMER_W-1:0]    hello_time_reg;
    logic                  tx_lock_reg;
    logic [FIELD_INST-1:0] msti_mask_reg;

    stptx_cfg_t       cfg;
    stptx_item_t      item;
    stptx_lane_flag_t lane_flag [LANE_COUNT];
    stptx_result_t    res_next;
    stptx_result_t    res_reg;
    logic             out_valid_reg;
    logic             in_fire;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_limit_reg <= RST_TX_HOLD_LIMIT;
            hello_time_reg <= RST_HELLO_TIME;
            tx_lock_reg    <= RST_TX_LOCK;
            msti_mask_reg  <= RST_MSTI_MASK;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_TX_HOLD_LIMIT: hold_limit_reg <= cfg_data[COUNT_W-1:0];
                REG_HELLO_TIME:    hello_time_reg <= cfg_data[TIMER_W-1:0];
                REG_TX_LOCK:       tx_lock_reg    <= cfg_data[0];
                REG_MSTI_MASK:     msti_mask_reg  <= cfg_data[FIELD_INST-1:0];
                default:           ;
            endcase
        end
    end

    assign cfg.hold_limit = hold_limit_reg;
    assign cfg.hello_time = hello_time_reg;
    assign cfg.lock       = tx_lock_reg;

    assign item.begin_flag     = begin_flag;
    assign item.port_up        = port_up;
    assign item.bpdu_filtered  = bpdu_filtered;
    assign item.transmit_ready = transmit_ready;
    assign item.hello_left     = hello_left;
    assign item.sent_count     = sent_count;
    assign item.rstp_mode      = rstp_mode;
    assign item.pending_info   = pending_info;
    assign item.cist_role      = cist_role;
    assign item.cist_tc_active = cist_tc_active;

    // One lane per examined instance
    for (genvar g = 0; g < LANE_COUNT; g++)
    begin : g_lane
        stptx_lane u_lane (
            .role      (msti_roles[ROLE_W*g +: ROLE_W]),
            .tc_active (msti_tc_active[g]),
            .present   (msti_mask_reg[g]),
            .flag      (lane_flag[g])
        );
    end

    stptx_decide #(
        .LANE_COUNT (LANE_COUNT)
    ) u_decide (
        .item      (item),
        .cfg       (cfg),
        .lane_flag (lane_flag),
        .res       (res_next)
    );

    // Output register; takes a new beat when empty or being drained
    assign in_ready = !out_valid_reg || out_ready;
    assign in_fire  = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (in_ready)
            out_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
            res_reg <= res_next;
    end

    assign out_valid         = out_valid_reg;
    assign send_kind         = res_reg.kind;
    assign pending_info_next = res_reg.info;
    assign sent_count_next   = res_reg.count;
    assign hello_left_next   = res_reg.hello;
    assign clear_tc_ack      = res_reg.clr;
    assign skipped           = res_reg.skip;

    // Checks
    `ASSERT_IMPLIES(a_stall_blocks_input, out_valid && !out_ready, !in_ready,
        "input taken while result beat is stalled")
    `ASSERT_IMPLIES(a_skip_sends_nothing, out_valid && skipped,
        (send_kind == SEND_NONE) && !clear_tc_ack, "skipped beat sends a BPDU")
    `ASSERT_IMPLIES(a_send_clears_info, out_valid && (send_kind != SEND_NONE),
        pending_info_next == '0, "info flags left set after a send")
    `ASSERT_CLK(a_clr_only_on_send,
        !(out_valid && clear_tc_ack) || (send_kind == SEND_CONFIG) ||
        (send_kind == SEND_RSTP), "tc ack cleared without config or RSTP BPDU")

endmodule

// ===== rtl/stptx_lane.sv =====
`timescale 1ns / 1ps

// One MSTI lane: classifies that instance's role for the periodic pass
// and the master check.
module stptx_lane
    import stptx_pkg::*;
(
    input  logic [ROLE_W-1:0] role,
    input  logic              tc_active,
    input  logic              present,
    output stptx_lane_flag_t  flag
);

    always_comb
    begin
        flag.upd    = present &&
                      ((role == ROLE_DESIG) || ((role == ROLE_ROOT) && tc_active));
        flag.master = present && (role == ROLE_MASTER);
    end

endmodule

// ===== rtl/stptx_decide.sv =====
`timescale 1ns / 1ps

// Merge of lane flags plus the transmit decision for one port.
module stptx_decide
    import stptx_pkg::*;
#(
    parameter int LANE_COUNT = FIELD_INST
)
(
    input  stptx_item_t      item,
    input  stptx_cfg_t       cfg,
    input  stptx_lane_flag_t lane_flag [LANE_COUNT],
    output stptx_result_t    res
);

    logic               msti_upd;
    logic               msti_master;
    logic               skip;
    logic               init;
    logic               periodic;
    logic               cist_upd;
    logic [INFO_W-1:0]  info_p;
    logic [TIMER_W-1:0] hello_p;
    logic [KIND_W-1:0]  kind;

    // OR the lane flags together
    always_comb
    begin
        msti_upd    = 1'b0;
        msti_master = 1'b0;
        for (int i = 0; i < LANE_COUNT; i++)
        begin
            msti_upd    = msti_upd | lane_flag[i].upd;
            msti_master = msti_master | lane_flag[i].master;
        end
    end

    assign skip     = (item.bpdu_filtered && !item.begin_flag) || cfg.lock;
    assign init     = item.begin_flag || !item.port_up;
    assign periodic = (item.hello_left == '0);
    assign cist_upd = (item.cist_role == ROLE_DESIG) ||
                      ((item.cist_role == ROLE_ROOT) && item.cist_tc_active);

    // Periodic pass on hello expiry
    always_comb
    begin
        info_p  = item.pending_info;
        hello_p = item.hello_left;
        if (periodic)
        begin
            info_p  = item.pending_info | {msti_upd, cist_upd};
            hello_p = cfg.hello_time;
        end
    end

    // BPDU kind, gated by hello and the hold limit
    always_comb
    begin
        kind = SEND_NONE;
        if ((hello_p != '0) && (item.sent_count < cfg.hold_limit))
        begin
            if (!item.rstp_mode)
            begin
                if (info_p[0] && (item.cist_role == ROLE_DESIG))
                    kind = SEND_CONFIG;
                else if (info_p[0] && (item.cist_role == ROLE_ROOT))
                    kind = SEND_TCN;
            end
            else if (info_p[0] || (info_p[1] && !msti_master))
            begin
                kind = SEND_RSTP;
            end
        end
    end

    // Result selection
    always_comb
    begin
        res.kind  = SEND_NONE;
        res.info  = item.pending_info;
        res.count = item.sent_count;
        res.hello = item.hello_left;
        res.clr   = 1'b0;
        res.skip  = 1'b0;
        if (skip)
        begin
            res.skip = 1'b1;
        end
        else if (init)
        begin
            res.info  = '1;
            res.count = '0;
            res.hello = cfg.hello_time;
        end
        else if (item.transmit_ready)
        begin
            res.info  = info_p;
            res.hello = hello_p;
            res.kind  = kind;
            res.clr   = (kind == SEND_CONFIG) || (kind == SEND_RSTP);
            if (kind != SEND_NONE)
            begin
                res.info  = '0;
                res.count = COUNT_W'(item.sent_count + 4'd1);
                res.hello = cfg.hello_time;
            end
        end
    end

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import stptx_pkg::*;

    // Instance lanes the decision looks at
    localparam int LANES = (MSTI_COUNT_DEF > FIELD_INST) ? FIELD_INST : MSTI_COUNT_DEF;
    localparam int CYCLE_LIMIT = 200000;
    localparam int RANDOM_PHASES = 12;
    localparam int PHASE_BEATS = 92;

    // One input beat: port variables plus the per-instance fields
    typedef struct packed {
        stptx_item_t           port;
        logic [31:0]           roles;
        logic [FIELD_INST-1:0] tc;
    } port_beat_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_W-1:0]      cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [KIND_W-1:0]     send_kind;
    logic [INFO_W-1:0]     pending_info_next;
    logic [COUNT_W-1:0]    sent_count_next;
    logic [TIMER_W-1:0]    hello_left_next;
    logic                  clear_tc_ack;
    logic                  skipped;
    port_beat_t            tx_beat = '0;

    // Bridge settings as last programmed
    stptx_cfg_t            port_cfg;
    logic [FIELD_INST-1:0] present_mask;

    port_beat_t            pending_beats[$];
    stptx_result_t         expected_results[$];

    int unsigned           tx_idle_pct = 11;
    int unsigned           rx_stall_pct = 74;
    int unsigned           mismatches = 0;
    int unsigned           cycles = 0;
    int unsigned           beats_issued = 0;
    logic                  in_taken = 1'b0;
    logic                  drain_hold = 1'b0;

    stp_port_transmit_decision_core dut
    (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .begin_flag        (tx_beat.port.begin_flag),
        .port_up           (tx_beat.port.port_up),
        .bpdu_filtered     (tx_beat.port.bpdu_filtered),
        .transmit_ready    (tx_beat.port.transmit_ready),
        .hello_left        (tx_beat.port.hello_left),
        .sent_count        (tx_beat.port.sent_count),
        .rstp_mode         (tx_beat.port.rstp_mode),
        .pending_info      (tx_beat.port.pending_info),
        .cist_role         (tx_beat.port.cist_role),
        .cist_tc_active    (tx_beat.port.cist_tc_active),
        .msti_roles        (tx_beat.roles),
        .msti_tc_active    (tx_beat.tc),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .send_kind         (send_kind),
        .pending_info_next (pending_info_next),
        .sent_count_next   (sent_count_next),
        .hello_left_next   (hello_left_next),
        .clear_tc_ack      (clear_tc_ack),
        .skipped           (skipped)
    );

    // Clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Transmit decision for one port under the current settings
    function automatic stptx_result_t predict_transmit(port_beat_t b);
        stptx_result_t r;
        logic [ROLE_W-1:0] role;
        logic msti_upd;
        logic master_seen;
        int i;
        r.kind = SEND_NONE;
        r.info = b.port.pending_info;
        r.count = b.port.sent_count;
        r.hello = b.port.hello_left;
        r.clr = 1'b0;
        r.skip = 1'b0;
        msti_upd = 1'b0;
        master_seen = 1'b0;
        if ((b.port.bpdu_filtered && !b.port.begin_flag) || port_cfg.lock)
        begin
            r.skip = 1'b1;
        end
        else if (b.port.begin_flag || !b.port.port_up)
        begin
            r.info = '1;
            r.count = '0;
            r.hello = port_cfg.hello_time;
        end
        else if (b.port.transmit_ready)
        begin
            // scan configured instances once; roles do not change during the call
            for (i = 0; i < LANES; i++)
            begin
                role = b.roles[2*i +: 2];
                if (present_mask[i])
                begin
                    if (role == ROLE_DESIG || (role == ROLE_ROOT && b.tc[i]))
                        msti_upd = 1'b1;
                    if (role == ROLE_MASTER)
                        master_seen = 1'b1;
                end
            end
            // periodic pass on hello expiry
            if (r.hello == '0)
            begin
                if (b.port.cist_role == ROLE_DESIG ||
                    (b.port.cist_role == ROLE_ROOT && b.port.cist_tc_active))
                    r.info[0] = 1'b1;
                if (msti_upd)
                    r.info[1] = 1'b1;
                r.hello = port_cfg.hello_time;
            end
            // send decision
            if (r.hello != '0 && r.count < port_cfg.hold_limit)
            begin
                if (!b.port.rstp_mode)
                begin
                    if (r.info[0] && b.port.cist_role == ROLE_DESIG)
                    begin
                        r.kind = SEND_CONFIG;
                        r.clr = 1'b1;
                    end
                    else if (r.info[0] && b.port.cist_role == ROLE_ROOT)
                    begin
                        r.kind = SEND_TCN;
                    end
                end
                else if (r.info[0] || (r.info[1] && !master_seen))
                begin
                    r.kind = SEND_RSTP;
                    r.clr = 1'b1;
                end
                if (r.kind != SEND_NONE)
                begin
                    r.info = '0;
                    r.count = r.count + 1'b1;
                    r.hello = port_cfg.hello_time;
                end
            end
        end
        return r;
    endfunction

    // Designated CIST port in legacy mode with fresh CIST info
    function automatic port_beat_t plain_beat();
        port_beat_t b;
        b = '0;
        b.port.port_up = 1'b1;
        b.port.transmit_ready = 1'b1;
        b.port.hello_left = 4'd5;
        b.port.pending_info = 2'b01;
        b.port.cist_role = ROLE_DESIG;
        return b;
    endfunction

    // Mostly live ports that reach the send decision, some init and skip beats
    function automatic port_beat_t random_beat();
        port_beat_t b;
        int i;
        b.port.begin_flag = ($urandom_range(15) == 0);
        b.port.port_up = ($urandom_range(11) != 0);
        b.port.bpdu_filtered = ($urandom_range(11) == 0);
        b.port.transmit_ready = ($urandom_range(4) != 0);
        b.port.hello_left = ($urandom_range(2) == 0) ? 4'd0 : 4'($urandom_range(15));
        b.port.sent_count = ($urandom_range(4) == 0) ? 4'($urandom_range(15)) :
                            4'($urandom_range(port_cfg.hold_limit));
        b.port.rstp_mode = 1'($urandom_range(1));
        b.port.pending_info = INFO_W'($urandom_range(3));
        b.port.cist_role = ROLE_W'($urandom_range(3));
        b.port.cist_tc_active = 1'($urandom_range(1));
        b.roles = $urandom;
        b.tc = FIELD_INST'($urandom);
        // keep some beats free of master roles so MSTI-only info can go out
        if ($urandom_range(2) == 0)
        begin
            for (i = 0; i < FIELD_INST; i++)
            begin
                if (b.roles[2*i +: 2] == ROLE_MASTER)
                    b.roles[2*i +: 2] = ROLE_W'($urandom_range(2));
            end
        end
        return b;
    endfunction

    // Program all four registers, one write per cycle
    task automatic apply_setting(input logic [3:0] hold, input logic [3:0] hello,
                                 input logic lock, input logic [15:0] mask);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= REG_TX_HOLD_LIMIT;
        cfg_data <= CFG_W'(hold);
        @(negedge clk);
        cfg_index <= REG_HELLO_TIME;
        cfg_data <= CFG_W'(hello);
        @(negedge clk);
        cfg_index <= REG_TX_LOCK;
        cfg_data <= CFG_W'(lock);
        @(negedge clk);
        cfg_index <= REG_MSTI_MASK;
        cfg_data <= mask;
        @(negedge clk);
        cfg_we <= 1'b0;
        port_cfg.hold_limit = hold;
        port_cfg.hello_time = hello;
        port_cfg.lock = lock;
        present_mask = mask;
    endtask

    // Block until every queued beat went in and every result came back
    task automatic wait_idle();
        while (pending_beats.size() != 0 || in_valid || expected_results.size() != 0)
            @(posedge clk);
        repeat (2) @(negedge clk);
    endtask

    task automatic check_field(input string name, input logic [3:0] want,
                               input logic [3:0] got);
        if (want !== got)
        begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    // Driver: new beat only once the previous one was taken
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            out_ready <= ($urandom_range(99) >= rx_stall_pct);
            if (drain_hold && !in_valid && expected_results.size() == 0)
                drain_hold = 1'b0;
            if (!in_valid || in_taken)
            begin
                if (pending_beats.size() != 0 && !drain_hold &&
                    $urandom_range(99) >= tx_idle_pct)
                begin
                    tx_beat <= pending_beats.pop_front();
                    in_valid <= 1'b1;
                    beats_issued++;
                    // now and then let the pipe run dry before the next beat
                    if (beats_issued % 211 == 50)
                        drain_hold = 1'b1;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: predict on accepted input, compare on accepted output
    always @(posedge clk)
    begin
        stptx_result_t want;
        in_taken = rst_n && in_valid && in_ready;
        if (rst_n)
        begin
            if (in_valid && in_ready)
                expected_results.push_back(predict_transmit(tx_beat));
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: result beat, expected none, actual kind %0d",
                             $time, send_kind);
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("send_kind", 4'(want.kind), 4'(send_kind));
                    check_field("pending_info_next", 4'(want.info), 4'(pending_info_next));
                    check_field("sent_count_next", want.count, sent_count_next);
                    check_field("hello_left_next", want.hello, hello_left_next);
                    check_field("clear_tc_ack", 4'(want.clr), 4'(clear_tc_ack));
                    check_field("skipped", 4'(want.skip), 4'(skipped));
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("stp_port_transmit_decision_core test failed");
            $finish;
        end
    end

    // Stimulus sequence
    initial
    begin
        port_beat_t b;
        int k;
        int n;
        port_cfg.hold_limit = RST_TX_HOLD_LIMIT;
        port_cfg.hello_time = RST_HELLO_TIME;
        port_cfg.lock = RST_TX_LOCK;
        present_mask = RST_MSTI_MASK;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: every branch of the decision with roomy limits
        apply_setting(4'd10, 4'd10, 1'b0, 16'hFFFF);
        b = plain_beat(); b.port.begin_flag = 1'b1; b.port.bpdu_filtered = 1'b1;
        pending_beats.push_back(b);
        b = plain_beat(); b.port.bpdu_filtered = 1'b1; pending_beats.push_back(b);
        b = plain_beat(); b.port.port_up = 1'b0; pending_beats.push_back(b);
        b = plain_beat(); b.port.transmit_ready = 1'b0; b.port.hello_left = 4'd15;
        b.port.sent_count = 4'd15; pending_beats.push_back(b);
        b = plain_beat(); b.port.hello_left = 4'd0; pending_beats.push_back(b);
        b = plain_beat(); b.port.cist_role = ROLE_ROOT; pending_beats.push_back(b);
        b = plain_beat(); b.port.cist_role = ROLE_OTHER; pending_beats.push_back(b);
        b = plain_beat(); b.port.cist_role = ROLE_MASTER; pending_beats.push_back(b);
        b = plain_beat(); b.port.rstp_mode = 1'b1; b.port.pending_info = 2'b10;
        b.roles = 32'hAAAA_AAAA; pending_beats.push_back(b);
        b = plain_beat(); b.port.rstp_mode = 1'b1; b.port.pending_info = 2'b10;
        b.roles = '1; pending_beats.push_back(b);
        b = plain_beat(); b.port.sent_count = 4'd10; pending_beats.push_back(b);
        b = plain_beat(); b.port.sent_count = 4'd9; pending_beats.push_back(b);
        b = plain_beat(); b.port.pending_info = 2'b00; b.port.hello_left = 4'd0;
        b.port.cist_role = ROLE_ROOT; b.port.cist_tc_active = 1'b1; pending_beats.push_back(b);
        b = plain_beat(); b.port.pending_info = 2'b00; b.port.hello_left = 4'd0;
        b.port.rstp_mode = 1'b1; b.port.cist_role = ROLE_OTHER; b.roles = 32'h5555_5555;
        b.tc = '1; pending_beats.push_back(b);
        b.tc = '0; pending_beats.push_back(b);
        b = plain_beat(); b.port.pending_info = 2'b00; b.port.rstp_mode = 1'b1;
        pending_beats.push_back(b);
        b = '0; pending_beats.push_back(b);
        b = '1; pending_beats.push_back(b);
        wait_idle();

        // zero hold limit and zero hello time
        apply_setting(4'd0, 4'd0, 1'b0, 16'h0000);
        b = plain_beat(); b.port.hello_left = 4'd0; pending_beats.push_back(b);
        b = plain_beat(); pending_beats.push_back(b);
        wait_idle();

        // lock wins even during begin
        apply_setting(4'd15, 4'd1, 1'b1, 16'h8001);
        b = plain_beat(); b.port.begin_flag = 1'b1; pending_beats.push_back(b);
        b = plain_beat(); pending_beats.push_back(b);
        wait_idle();

        // random phases over a sweep of settings and flow-control mixes
        for (k = 0; k < RANDOM_PHASES; k++)
        begin
            tx_idle_pct = (k < 4) ? 11 : (k < 8) ? 74 : 0;
            rx_stall_pct = (k < 4) ? 74 : (k < 8) ? 11 : 0;
            case (k)
                0: apply_setting(4'd6, 4'd2, 1'b0, 16'h0000);
                1: apply_setting(4'd15, 4'd15, 1'b0, 16'hFFFF);
                2: apply_setting(4'd1, 4'd10, 1'b0, 16'h0001);
                3: apply_setting(4'd3, 4'd0, 1'b0, 16'h5A5A);
                4: apply_setting(4'd10, 4'd1, 1'b1, 16'hA5A5);
                default:
                    apply_setting(4'($urandom_range(15)), 4'($urandom_range(15)),
                                  ($urandom_range(7) == 0), 16'($urandom));
            endcase
            for (n = 0; n < PHASE_BEATS; n++)
                pending_beats.push_back(random_beat());
            wait_idle();
        end

        repeat (4) @(posedge clk);
        if (mismatches == 0)
            $display("stp_port_transmit_decision_core test passed");
        else
            $display("stp_port_transmit_decision_core test failed");
        $finish;
    end

endmodule
